// ----- sv/sdcm_pkg.sv -----
// Shared types and constants for the concentric square-to-disc mapping unit.
// Holds the wedge codes, the Q30 constants and the Horner divisor schedule.
// Depends on nothing; sdcm_front, sdcm_back and the testbench import it.
package sdcm_pkg;

  localparam int WB = 30;
  localparam int QUO_BITS = WB + 1;
  localparam logic [30:0] W_ONE = 31'h4000_0000;
  localparam logic [29:0] PI_QUARTER = 30'd843314857;
  localparam int OUT_CAP = 32767;
  localparam int RECIP_SHIFT = 33;
  localparam int HORNER_STEPS = 6;
  localparam int LANE_SIN = 0;
  localparam int LANE_COS = 1;

  typedef enum logic [1:0] {
    WEDGE_RIGHT,
    WEDGE_TOP,
    WEDGE_LEFT,
    WEDGE_BOTTOM
  } wedge_t;

  // Each Horner divisor is split into a power of two and an odd factor.
  function automatic int step_shift(int lane, int s);
    int v;
    v = 0;
    if (lane == LANE_SIN) begin
      case (s)
        0: v = 1;
        1: v = 3;
        2: v = 1;
        3: v = 2;
        4: v = 1;
        default: v = 0;
      endcase
    end else begin
      case (s)
        0: v = 2;
        1: v = 1;
        2: v = 3;
        3: v = 1;
        4: v = 2;
        default: v = 1;
      endcase
    end
    return v;
  endfunction

  function automatic int step_odd(int lane, int s);
    int v;
    v = 1;
    if (lane == LANE_SIN) begin
      case (s)
        0: v = 55;
        1: v = 9;
        2: v = 21;
        3: v = 5;
        4: v = 3;
        default: v = 1;
      endcase
    end else begin
      case (s)
        0: v = 33;
        1: v = 45;
        2: v = 7;
        3: v = 15;
        4: v = 3;
        default: v = 1;
      endcase
    end
    return v;
  endfunction

endpackage

// ----- sv/sdcm_if.sv -----
// Handshake interfaces for the square points coming in and the disc points going out.
// Each carries valid, ready and the payload; no package dependency.
interface sdcm_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] square_x;
  logic [15:0] square_y;
  modport source (output valid, square_x, square_y, input ready);
  modport sink (input valid, square_x, square_y, output ready);
endinterface

interface sdcm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] disc_u;
  logic signed [15:0] disc_v;
  modport source (output valid, disc_u, disc_v, input ready);
  modport sink (input valid, disc_u, disc_v, output ready);
endinterface

// ----- sv/sdcm_front.sv -----
// Front end: accepts a square point, centres it and picks the wedge, radius and ratio operands.
// Uses sdcm_pkg and the sdcm_in_if interface.
module sdcm_front
  import sdcm_pkg::*;
#(
  parameter int FRAC_BITS = 15
) (
  input  logic                     clk,
  input  logic                     rst,
  sdcm_in_if.sink                  point,
  output logic                     item_valid,
  input  logic                     item_ready,
  output logic [3*FRAC_BITS+5:0]   item
);

  localparam int AW = FRAC_BITS + 2;
  localparam int CW = ((FRAC_BITS > 16) ? FRAC_BITS : 16) + 2;
  localparam logic [CW-1:0] ONE_C = {{(CW-1){1'b0}}, 1'b1} << FRAC_BITS;

  function automatic logic signed [AW-1:0] centre(logic [15:0] raw);
    logic [CW-1:0] v;
    logic [CW-1:0] d;
    v = CW'(raw);
    if (v > ONE_C) begin
      v = ONE_C;
    end
    d = (v << 1) - ONE_C;
    return d[AW-1:0];
  endfunction

  logic signed [AW-1:0] a, b, na, nb, rv, num, den;
  logic signed [AW-1:0] num_abs, den_abs;
  logic [FRAC_BITS:0]   r, nm, dm;
  wedge_t               wedge;
  logic                 flip, neg;

  always_comb begin
    a = centre(point.square_x);
    b = centre(point.square_y);
    na = -a;
    nb = -b;
    if (a > nb) begin
      if (a > b) begin
        wedge = WEDGE_RIGHT; rv = a; num = b; den = a; flip = 1'b0;
      end else begin
        wedge = WEDGE_TOP; rv = b; num = a; den = b; flip = 1'b1;
      end
    end else begin
      if (a < b) begin
        wedge = WEDGE_LEFT; rv = na; num = b; den = a; flip = 1'b0;
      end else begin
        wedge = WEDGE_BOTTOM; rv = nb; num = a; den = b; flip = 1'b1;
      end
    end
    num_abs = (num < 0) ? -num : num;
    den_abs = (den < 0) ? -den : den;
    r = rv[FRAC_BITS:0];
    if (den == '0) begin
      nm = '0;
      dm = {{FRAC_BITS{1'b0}}, 1'b1};
    end else begin
      nm = num_abs[FRAC_BITS:0];
      dm = den_abs[FRAC_BITS:0];
    end
    neg = ((num < 0) != (den < 0)) != flip;
  end

  assign point.ready = !item_valid || item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (point.ready) begin
      item_valid <= point.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (point.valid && point.ready) begin
      item <= {r, nm, dm, wedge, neg};
    end
  end

endmodule

// ----- sv/sdcm_queue.sv -----
// Four-entry queue that decouples the front end from the arithmetic back end.
// Generic payload width; no package dependency.
module sdcm_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  localparam int DEPTH = 4;
  localparam int PW = $clog2(DEPTH);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0]   count;
  logic          push, pop;

  assign push_ready = count != (PW+1)'(DEPTH);
  assign pop_valid = count != '0;
  assign pop_data = mem[rd_ptr];
  assign push = push_valid && push_ready;
  assign pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- sv/sdcm_back.sv -----
// Back end: ratio divider, angle scaling, sine and cosine by Horner stages, output scaling.
// Uses sdcm_pkg and the sdcm_out_if interface; fed from sdcm_queue.
module sdcm_back
  import sdcm_pkg::*;
#(
  parameter int FRAC_BITS = 15
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  logic [3*FRAC_BITS+5:0] item,
  sdcm_out_if.source             disc
);

  localparam int F = FRAC_BITS;
  localparam int HS = HORNER_STEPS;
  localparam int DIV0 = 0;
  localparam int TH_IDX = QUO_BITS;
  localparam int X2_IDX = TH_IDX + 1;
  localparam int H0_IDX = X2_IDX + 1;
  localparam int SC_IDX = H0_IDX + 3*HS;
  localparam int NST = SC_IDX + 1;
  localparam int XN = 3*(HS-1) + 1;
  localparam int PUW = F + 32;
  localparam int PW = F + 2;
  localparam int LIM = (F >= 15) ? OUT_CAP : ((1 << F) - 1);
  localparam logic [PUW-1:0] HALF = {{(PUW-1){1'b0}}, 1'b1} << (WB-1);

  typedef struct packed {
    logic [F:0] r;
    wedge_t     wedge;
    logic       neg;
  } side_t;

  function automatic logic [15:0] round_sat(logic [PUW-1:0] prod, logic neg);
    logic [PUW-1:0] sum;
    logic [PW-1:0]  p;
    logic [15:0]    m;
    sum = prod + HALF;
    p = sum[PUW-1:WB];
    if (p > PW'(LIM)) begin
      m = 16'(LIM);
    end else begin
      m = 16'(p);
    end
    return neg ? (~m + 16'd1) : m;
  endfunction

  logic              adv;
  logic [NST-1:0]    vld;
  side_t             sd [NST];
  side_t             it_side;
  logic [F:0]        it_r, it_nm, it_dm;
  logic [1:0]        it_wb;
  logic              it_neg;

  assign adv = !disc.valid || disc.ready;
  assign item_ready = adv;
  assign {it_r, it_nm, it_dm, it_wb, it_neg} = item;
  assign it_side = '{r: it_r, wedge: wedge_t'(it_wb), neg: it_neg};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      disc.valid <= 1'b0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], item_valid};
      disc.valid <= vld[NST-1];
    end
  end

  for (genvar k = 0; k < NST; k++) begin : g_side
    if (k == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (adv) begin
          sd[k] <= it_side;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (adv) begin
          sd[k] <= sd[k-1];
        end
      end
    end
  end

  // Restoring divider, one quotient bit per stage, most significant first.
  logic [F:0]          rem [QUO_BITS];
  logic [F:0]          dvs [QUO_BITS];
  logic [QUO_BITS-1:0] quo [QUO_BITS];

  for (genvar k = 0; k < QUO_BITS; k++) begin : g_div
    logic [F+1:0]        trial, diff;
    logic [F:0]          dv_in;
    logic [QUO_BITS-1:0] q_in;
    logic                qb;
    if (k == DIV0) begin : g_first
      assign trial = {1'b0, it_nm};
      assign dv_in = it_dm;
      assign q_in = '0;
    end else begin : g_next
      assign trial = {rem[k-1], 1'b0};
      assign dv_in = dvs[k-1];
      assign q_in = quo[k-1];
    end
    assign diff = trial - {1'b0, dv_in};
    assign qb = trial >= {1'b0, dv_in};
    always_ff @(posedge clk) begin
      if (adv) begin
        rem[k] <= qb ? diff[F:0] : trial[F:0];
        dvs[k] <= dv_in;
        quo[k] <= {q_in[QUO_BITS-2:0], qb};
      end
    end
  end

  // Angle and its square.
  logic [60:0] th_prod, x2_prod;
  logic [29:0] th;
  logic [29:0] xs [XN];
  logic [29:0] ths [XN];

  assign th_prod = 61'(quo[QUO_BITS-1]) * 61'(PI_QUARTER);
  assign x2_prod = 61'(th) * 61'(th);

  always_ff @(posedge clk) begin
    if (adv) begin
      th <= th_prod[WB+29:WB];
      xs[0] <= x2_prod[WB+29:WB];
      ths[0] <= th;
    end
  end

  for (genvar j = 0; j < XN-1; j++) begin : g_xs
    always_ff @(posedge clk) begin
      if (adv) begin
        xs[j+1] <= xs[j];
        ths[j+1] <= ths[j];
      end
    end
  end

  // Horner lanes: each step is multiply, reciprocal multiply, correct and subtract.
  logic [29:0] ma [2][HS];
  logic [29:0] mb_sh [2][HS];
  logic [29:0] mb_q [2][HS];
  logic [30:0] tt [2][HS];

  for (genvar L = 0; L < 2; L++) begin : g_lane
    for (genvar s = 0; s < HS; s++) begin : g_step
      localparam bit FIN = (L == LANE_SIN) && (s == HS-1);
      localparam int SH = step_shift(L, s);
      localparam int ODD = step_odd(L, s);
      localparam longint unsigned RECIP = (64'd1 << RECIP_SHIFT) / ODD;
      localparam logic [31:0] RECIP32 = 32'(RECIP);
      logic [29:0] mul_a, msh, qraw, qfix;
      logic [30:0] t_in;
      logic [60:0] prod_a;
      logic [61:0] prod_b;
      logic [35:0] back_mul, rem_c;
      logic        corr;

      if (s == 0) begin : g_t0
        assign t_in = W_ONE;
      end else begin : g_tn
        assign t_in = tt[L][s-1];
      end
      assign mul_a = FIN ? ths[3*s] : xs[3*s];
      assign prod_a = 61'(mul_a) * 61'(t_in);
      assign msh = ma[L][s] >> SH;
      assign prod_b = 62'(msh) * 62'(RECIP32);
      assign qraw = (ODD > 1) ? prod_b[RECIP_SHIFT+29:RECIP_SHIFT] : msh;
      assign back_mul = 36'(mb_q[L][s]) * 36'(ODD);
      assign rem_c = 36'(mb_sh[L][s]) - back_mul;
      assign corr = (ODD > 1) && (rem_c >= 36'(ODD));
      assign qfix = mb_q[L][s] + 30'(corr);

      always_ff @(posedge clk) begin
        if (adv) begin
          ma[L][s] <= prod_a[WB+29:WB];
          mb_sh[L][s] <= msh;
          mb_q[L][s] <= qraw;
          tt[L][s] <= FIN ? {1'b0, mb_sh[L][s]} : (W_ONE - {1'b0, qfix});
        end
      end
    end
  end

  // Quarter-turn rotation and scaling by the radius.
  logic [30:0]    sn, cs, mu, mv;
  logic           nu_c, nv_c, nu, nv;
  logic [PUW-1:0] pu, pv;
  side_t          sh;

  assign sn = tt[LANE_SIN][HS-1];
  assign cs = tt[LANE_COS][HS-1];
  assign sh = sd[SC_IDX-1];

  always_comb begin
    case (sh.wedge)
      WEDGE_RIGHT: begin
        mu = cs; nu_c = 1'b0; mv = sn; nv_c = sh.neg;
      end
      WEDGE_TOP: begin
        mu = sn; nu_c = !sh.neg; mv = cs; nv_c = 1'b0;
      end
      WEDGE_LEFT: begin
        mu = cs; nu_c = 1'b1; mv = sn; nv_c = !sh.neg;
      end
      default: begin
        mu = sn; nu_c = sh.neg; mv = cs; nv_c = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pu <= PUW'(sh.r) * PUW'(mu);
      pv <= PUW'(sh.r) * PUW'(mv);
      nu <= nu_c;
      nv <= nv_c;
      disc.disc_u <= round_sat(pu, nu);
      disc.disc_v <= round_sat(pv, nv);
    end
  end

  a_quo_bound: assert property (@(posedge clk) disable iff (rst)
    vld[QUO_BITS-1] |-> quo[QUO_BITS-1] <= {1'b1, {WB{1'b0}}})
    else $error("ratio quotient above one");

  a_cos_bound: assert property (@(posedge clk) disable iff (rst)
    vld[SC_IDX-1] |-> (cs <= W_ONE && sn < W_ONE))
    else $error("trig term out of range");

  a_centre_zero: assert property (@(posedge clk) disable iff (rst)
    (adv && vld[NST-1] && sd[NST-1].r == '0) |=>
      (disc.disc_u == 16'sd0 && disc.disc_v == 16'sd0))
    else $error("zero radius gave nonzero output");

  a_no_min: assert property (@(posedge clk) disable iff (rst)
    disc.valid |-> (disc.disc_u != 16'sh8000 && disc.disc_v != 16'sh8000))
    else $error("output outside saturation range");

endmodule

// ----- sv/square_to_disc_concentric_map_unit.sv -----
// Throughput: one transaction per cycle while the output register is free or taken;
// the 31-stage divider and Horner stages are fully pipelined.
// The back end pipeline advances as one unit whenever the output register is free or taken.
// A four-entry queue lets the front end keep accepting while the output is stalled.
// Reset (rst, synchronous) clears valid flags and queue pointers; data registers are not reset.
module square_to_disc_concentric_map_unit #(
  parameter int FRAC_BITS = 15
) (
  input  logic       clk,
  input  logic       rst,
  sdcm_in_if.sink    point,
  sdcm_out_if.source disc
);

  localparam int ITEM_W = 3*FRAC_BITS + 6;

  logic              f_valid, f_ready, b_valid, b_ready;
  logic [ITEM_W-1:0] f_item, b_item;

  sdcm_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .point      (point),
    .item_valid (f_valid),
    .item_ready (f_ready),
    .item       (f_item)
  );

  sdcm_queue #(.W(ITEM_W)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_item),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_item)
  );

  sdcm_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (b_valid),
    .item_ready (b_ready),
    .item       (b_item),
    .disc       (disc)
  );

endmodule

// ----- tb/sv/square_to_disc_concentric_map_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the concentric square-to-disc mapping unit.
// Depends on sdcm_pkg, the sdcm_in_if and sdcm_out_if interfaces and the unit itself.
module square_to_disc_concentric_map_unit_tb;
  import sdcm_pkg::*;

  localparam int FRAC = 15;
  localparam longint unsigned ONE_Q = 64'd1 << FRAC;
  localparam longint unsigned Q30 = 64'd1 << WB;
  localparam longint unsigned PIQ = 64'd843314857;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1040;

  typedef struct packed {
    logic signed [15:0] u;
    logic signed [15:0] v;
  } disc_pt_t;

  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
    bit          known;
    disc_pt_t    pt;
  } point_row_t;

  logic clk;
  logic rst;
  sdcm_in_if  point ();
  sdcm_out_if disc ();

  square_to_disc_concentric_map_unit #(.FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst(rst), .point(point.sink), .disc(disc.source)
  );

  disc_pt_t disc_expected[$];
  int mismatches;
  int cycles;
  int idle_pct;
  int stall_pct;

  always #5 clk = ~clk;

  function automatic longint unsigned q30_mul(longint unsigned p, longint unsigned q);
    return (p * q) >> WB;
  endfunction

  function automatic longint unsigned sine_q30(longint unsigned th);
    longint unsigned x2, t;
    x2 = q30_mul(th, th);
    t = Q30;
    t = Q30 - q30_mul(x2, t) / 110;
    t = Q30 - q30_mul(x2, t) / 72;
    t = Q30 - q30_mul(x2, t) / 42;
    t = Q30 - q30_mul(x2, t) / 20;
    t = Q30 - q30_mul(x2, t) / 6;
    return q30_mul(th, t);
  endfunction

  function automatic longint unsigned cosine_q30(longint unsigned th);
    longint unsigned x2, t;
    x2 = q30_mul(th, th);
    t = Q30;
    t = Q30 - q30_mul(x2, t) / 132;
    t = Q30 - q30_mul(x2, t) / 90;
    t = Q30 - q30_mul(x2, t) / 56;
    t = Q30 - q30_mul(x2, t) / 30;
    t = Q30 - q30_mul(x2, t) / 12;
    t = Q30 - q30_mul(x2, t) / 2;
    return t;
  endfunction

  function automatic logic [15:0] scale_radius(longint unsigned r, longint c);
    longint unsigned mag, p;
    mag = (c < 0) ? longint'(-c) : longint'(c);
    p = (r * mag + (Q30 >> 1)) >> WB;
    if (p > OUT_CAP) p = OUT_CAP;
    if (c < 0) p = -p;
    return p[15:0];
  endfunction

  function automatic longint centred(logic [15:0] raw);
    longint unsigned v;
    v = raw;
    if (v > ONE_Q) v = ONE_Q;
    return 2 * longint'(v) - longint'(ONE_Q);
  endfunction

  function automatic disc_pt_t map_point(logic [15:0] x, logic [15:0] y);
    longint a, b, r, num, den, sn, cs, cu, sv;
    longint unsigned ratio, th;
    bit flip, neg;
    wedge_t w;
    disc_pt_t res;
    a = centred(x);
    b = centred(y);
    if (a > -b) begin
      if (a > b) begin
        w = WEDGE_RIGHT; r = a; num = b; den = a; flip = 0;
      end else begin
        w = WEDGE_TOP; r = b; num = a; den = b; flip = 1;
      end
    end else begin
      if (a < b) begin
        w = WEDGE_LEFT; r = -a; num = b; den = a; flip = 0;
      end else begin
        w = WEDGE_BOTTOM; r = -b; num = a; den = b; flip = 1;
      end
    end
    ratio = 0;
    neg = 0;
    if (den != 0) begin
      ratio = ((num < 0 ? -num : num) << WB) / (den < 0 ? -den : den);
      neg = ((num < 0) != (den < 0)) != flip;
    end
    th = (ratio * PIQ) >> WB;
    sn = longint'(sine_q30(th));
    cs = longint'(cosine_q30(th));
    if (neg) sn = -sn;
    case (w)
      WEDGE_RIGHT: begin cu = cs;  sv = sn;  end
      WEDGE_TOP:   begin cu = -sn; sv = cs;  end
      WEDGE_LEFT:  begin cu = -cs; sv = -sn; end
      default:     begin cu = sn;  sv = -cs; end
    endcase
    res.u = scale_radius(r, cu);
    res.v = scale_radius(r, sv);
    return res;
  endfunction

  task automatic send_point(logic [15:0] x, logic [15:0] y, bit known, disc_pt_t pt);
    while ($urandom_range(99) < idle_pct) begin
      point.valid <= 1'b0;
      @(posedge clk);
    end
    point.valid <= 1'b1;
    point.square_x <= x;
    point.square_y <= y;
    @(posedge clk);
    while (!point.ready) @(posedge clk);
    disc_expected.push_back(known ? pt : map_point(x, y));
  endtask

  function automatic logic [15:0] random_coord();
    int k;
    k = $urandom_range(99);
    if (k < 70) return 16'($urandom_range(32768));
    if (k < 85) return 16'($urandom_range(3) * 16384 + $urandom_range(2) - 1);
    return 16'($urandom);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) disc.ready <= ($urandom_range(99) >= stall_pct);
    if (disc.valid && disc.ready) begin
      if (disc_expected.size() == 0) begin
        $error("disc result with none expected: u=%0d v=%0d", disc.disc_u, disc.disc_v);
        mismatches++;
      end else begin
        if (disc.disc_u !== disc_expected[0].u) begin
          $error("disc_u expected %0d actual %0d", disc_expected[0].u, disc.disc_u);
          mismatches++;
        end
        if (disc.disc_v !== disc_expected[0].v) begin
          $error("disc_v expected %0d actual %0d", disc_expected[0].v, disc.disc_v);
          mismatches++;
        end
        void'(disc_expected.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("square_to_disc_concentric_map_unit_tb: errors");
      $finish;
    end
  end

  initial begin
    point_row_t rows[$];
    point_row_t row;
    logic [15:0] x, y;
    int k;
    clk = 0;
    rst = 1;
    cycles = 0;
    mismatches = 0;
    idle_pct = 0;
    stall_pct = 0;
    point.valid = 0;
    point.square_x = 0;
    point.square_y = 0;
    disc.ready = 0;

    rows.push_back('{16'd16384, 16'd16384, 1, '{16'sd0, 16'sd0}});
    rows.push_back('{16'd32768, 16'd16384, 1, '{16'sd32767, 16'sd0}});
    rows.push_back('{16'd0, 16'd16384, 1, '{-16'sd32767, 16'sd0}});
    rows.push_back('{16'd16384, 16'd32768, 1, '{16'sd0, 16'sd32767}});
    rows.push_back('{16'd16384, 16'd0, 1, '{16'sd0, -16'sd32767}});
    rows.push_back('{16'd65535, 16'd16384, 1, '{16'sd32767, 16'sd0}});
    rows.push_back('{16'd16384, 16'd65535, 1, '{16'sd0, 16'sd32767}});
    rows.push_back('{16'd0, 16'd0, 0, '0});
    rows.push_back('{16'd32768, 16'd32768, 0, '0});
    rows.push_back('{16'd0, 16'd32768, 0, '0});
    rows.push_back('{16'd32768, 16'd0, 0, '0});
    rows.push_back('{16'd65535, 16'd65535, 0, '0});
    rows.push_back('{16'd32769, 16'd0, 0, '0});
    rows.push_back('{16'd16385, 16'd16384, 0, '0});
    rows.push_back('{16'd16384, 16'd16383, 0, '0});
    rows.push_back('{16'd24576, 16'd24576, 0, '0});
    rows.push_back('{16'd8192, 16'd24576, 0, '0});
    rows.push_back('{16'd8192, 16'd8192, 0, '0});
    rows.push_back('{16'd24576, 16'd8192, 0, '0});
    rows.push_back('{16'd30000, 16'd20000, 0, '0});
    rows.push_back('{16'd1, 16'd32767, 0, '0});
    rows.push_back('{16'd43690, 16'd21845, 0, '0});

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      row = rows[i];
      send_point(row.x, row.y, row.known, row.pt);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      case (n / (RANDOM_ITEMS / 4))
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 60; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 60; end
        default: begin idle_pct = 30; stall_pct = 30; end
      endcase
      if (n % 50 < 5) begin
        idle_pct = 0;
        stall_pct = 0;
      end
      x = random_coord();
      k = $urandom_range(9);
      if (k == 0) y = x;
      else if (k == 1 && x <= 32768) y = 16'd32768 - x;
      else y = random_coord();
      send_point(x, y, 0, '0);
    end
    point.valid <= 1'b0;
    stall_pct = 0;

    while (disc_expected.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0) begin
      $display("square_to_disc_concentric_map_unit_tb: clean");
    end else begin
      $display("square_to_disc_concentric_map_unit_tb: errors");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
sv/sdcm_pkg.sv
sv/sdcm_if.sv
sv/sdcm_front.sv
sv/sdcm_queue.sv
sv/sdcm_back.sv
sv/square_to_disc_concentric_map_unit.sv
tb/sv/square_to_disc_concentric_map_unit_tb.sv
